FILE: design/assert_macros.svh
// Assertion macros shared by the matrix series design.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/m3os_pkg.sv
// Package for the 3x3 matrix re-orthogonalization pipeline.
// Holds element and matrix types and the default fraction width; no dependencies.
`default_nettype none

package m3os_pkg;

    localparam int FRAC_BITS_DEF = 29;
    localparam int NUM_EL        = 9;
    localparam int ELEM_W        = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;
    // Row-major, element r*3+c; element 0 sits in the lowest bits.
    typedef elem_t [NUM_EL-1:0] mat_t;

endpackage

`default_nettype wire

FILE: design/m3os_matmul.sv
// Two-stage fixed-point 3x3 multiply-accumulate: res = sat(a*b + diag*I).
// Depends on m3os_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module m3os_matmul #(
    parameter int FRAC_BITS = m3os_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  m3os_pkg::mat_t      a,
    input  m3os_pkg::mat_t      b,
    input  m3os_pkg::elem_t     diag,
    input  wire  [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    input  wire                 out_ready,
    output m3os_pkg::mat_t      res,
    output logic [SIDE_W-1:0]   side_out
);
    import m3os_pkg::*;

    // Truncated product width and sum width.
    localparam int TW = 2 * ELEM_W - FRAC_BITS + 1;
    localparam int SW = TW + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sd2147483648);

    typedef logic signed [TW-1:0] trunc_t;

    logic        v1_reg, v2_reg;
    logic        adv1, adv2;
    trunc_t      prod_reg [27];
    trunc_t      prod_next [27];
    elem_t       diag_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg;
    mat_t        res_reg, res_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        logic signed [63:0] p;
        logic signed [63:0] t;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p = 64'($signed(a[r*3+k])) * 64'($signed(b[k*3+c]));
                    // Round toward zero by truncating the magnitude.
                    if (p < 0)
                        t = -((-p) >>> FRAC_BITS);
                    else
                        t = p >>> FRAC_BITS;
                    prod_next[(r*3+c)*3+k] = t[TW-1:0];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] s;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s = SW'(prod_reg[(r*3+c)*3]) + SW'(prod_reg[(r*3+c)*3+1])
                    + SW'(prod_reg[(r*3+c)*3+2]);
                if (r == c)
                    s = s + SW'(diag_reg);
                if (s > SAT_HI)
                    res_next[r*3+c] = elem_t'(SAT_HI[ELEM_W-1:0]);
                else if (s < SAT_LO)
                    res_next[r*3+c] = elem_t'(SAT_LO[ELEM_W-1:0]);
                else
                    res_next[r*3+c] = s[ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            prod_reg  <= prod_next;
            diag_reg  <= diag;
            side1_reg <= side_in;
        end
        if (adv2 && v1_reg)
        begin
            res_reg   <= res_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign res       = res_reg;
    assign side_out  = side2_reg;

    `ASSERT_NEXT(a_hold_out, v2_reg && !out_ready, v2_reg && $stable(res_reg),
        "stalled result lost or changed")
    `ASSERT_NEXT(a_hold_mid, v1_reg && !adv2, v1_reg && $stable(diag_reg),
        "stalled product stage lost")
    `ASSERT_IMPL(a_no_overrun, in_valid && in_ready && v1_reg, adv2,
        "product stage overwritten while full")

endmodule

`default_nettype wire

FILE: design/matrix3_orthogonalize_series_top.sv
// Top level of the 3x3 rotation matrix re-orthogonalization pipeline.
// Depends on m3os_pkg and m3os_matmul (five chained multiply units).
//
//  Channel | Direction | Payload (low bits first)
//  s_*     | in        | tdata: in_r0c0 .. in_r2c2, 9 x 32 bits
//  m_*     | out       | tdata: out_r0c0 .. out_r2c2, 9 x 32 bits
//
// Five matrix multiply units of two stages each (multiply, then sum and
// saturate). A new matrix is accepted every cycle while s_tready is high.
// Reset clears only the stage valid bits. Each stage moves when the one after
// it is empty or moving, so a stall fills bubbles first and drops nothing.
`default_nettype none

module matrix3_orthogonalize_series_top #(
    parameter int FRAC_BITS = m3os_pkg::FRAC_BITS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [287:0] s_tdata,  // in_r0c0, in_r0c1, ..., in_r2c2
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [287:0] m_tdata   // out_r0c0, out_r0c1, ..., out_r2c2
);
    import m3os_pkg::*;

    localparam int MW = NUM_EL * ELEM_W;
    localparam elem_t ONE      = elem_t'(64'sd1 <<< FRAC_BITS);
    localparam elem_t NEG_ONE  = -ONE;
    localparam elem_t NEG_HALF = -elem_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam elem_t THREE_8  = elem_t'(64'sd3 <<< (FRAC_BITS - 3));
    localparam elem_t NEG_5_16 = -elem_t'(64'sd5 <<< (FRAC_BITS - 4));
    localparam elem_t ZERO     = '0;

    mat_t m_in, m_t, scale_m;
    mat_t x0, a1, b2, a3, r4;
    logic [MW-1:0]   side0;
    logic [2*MW-1:0] side1, side2;
    logic [MW-1:0]   side3;
    logic v0, v1, v2, v3;
    logic rdy1, rdy2, rdy3, rdy4;

    assign m_in = mat_t'(s_tdata);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m_t[r*3+c]     = m_in[c*3+r];
                scale_m[r*3+c] = (r == c) ? NEG_5_16 : ZERO;
            end
        end
    end

    // X = M^T M - I
    m3os_matmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(MW)) u_x (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .a(m_t), .b(m_in), .diag(NEG_ONE), .side_in(s_tdata),
        .out_valid(v0), .out_ready(rdy1), .res(x0), .side_out(side0));

    // A = 3/8 I - 5/16 X, as X times a scaled identity.
    m3os_matmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2*MW)) u_a (
        .clk(clk), .rst_n(rst_n), .in_valid(v0), .in_ready(rdy1),
        .a(x0), .b(scale_m), .diag(THREE_8), .side_in({MW'(x0), side0}),
        .out_valid(v1), .out_ready(rdy2), .res(a1), .side_out(side1));

    // B = A X - 1/2 I
    m3os_matmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2*MW)) u_b (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_ready(rdy2),
        .a(a1), .b(mat_t'(side1[2*MW-1:MW])), .diag(NEG_HALF), .side_in(side1),
        .out_valid(v2), .out_ready(rdy3), .res(b2), .side_out(side2));

    // A' = B X + I
    m3os_matmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(MW)) u_ap (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .in_ready(rdy3),
        .a(b2), .b(mat_t'(side2[2*MW-1:MW])), .diag(ONE), .side_in(side2[MW-1:0]),
        .out_valid(v3), .out_ready(rdy4), .res(a3), .side_out(side3));

    // Result = M A'
    m3os_matmul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_res (
        .clk(clk), .rst_n(rst_n), .in_valid(v3), .in_ready(rdy4),
        .a(mat_t'(side3)), .b(a3), .diag(ZERO), .side_in(1'b0),
        .out_valid(m_tvalid), .out_ready(m_tready), .res(r4), .side_out());

    assign m_tdata = MW'(r4);

endmodule

`default_nettype wire
